@@ hw/rtl/czh_pkg.sv @@
// Package: shared constants, item kind codes and table port types for the Zobrist hash block.
`timescale 1ns / 1ps

package czh_pkg;

  localparam int unsigned TableWords  = 781;
  localparam int unsigned PieceWords  = 768;
  localparam int unsigned CastleBase  = 768;
  localparam int unsigned EpBase      = 772;
  localparam int unsigned TurnWord    = 780;
  localparam int unsigned Squares     = 64;
  localparam int unsigned CastleWords = 4;
  localparam int unsigned EpWords     = 8;
  localparam int unsigned MaxCode     = 11;

  localparam int unsigned IndexW   = 10;
  localparam int unsigned HashW    = 64;
  localparam int unsigned SquareW  = 6;
  localparam int unsigned CodeW    = 4;
  localparam int unsigned FileW    = 3;
  localparam int unsigned RankW    = 3;
  localparam int unsigned PieceAddrW = $clog2(PieceWords);

  localparam logic [CodeW-1:0] CodeBlackPawn = 4'd0;
  localparam logic [CodeW-1:0] CodeWhitePawn = 4'd1;
  localparam logic [RankW-1:0] RankWhiteEp   = 3'd4;
  localparam logic [RankW-1:0] RankBlackEp   = 3'd3;
  localparam logic [FileW-1:0] FileFirst     = 3'd0;
  localparam logic [FileW-1:0] FileLast      = 3'd7;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_NONE   = 2'd3
  } czh_kind_e;

  typedef struct packed {
    logic                  wr_en;
    logic [IndexW-1:0]     wr_index;
    logic [HashW-1:0]      wr_value;
    logic                  rd_en;
    logic [PieceAddrW-1:0] rd_addr;
  } czh_tbl_req_t;

  typedef struct packed {
    logic [HashW-1:0]                  piece_word;
    logic [CastleWords-1:0][HashW-1:0] castle_word;
    logic [EpWords-1:0][HashW-1:0]     ep_word;
    logic [HashW-1:0]                  turn_word;
  } czh_tbl_rsp_t;

endpackage

@@ hw/rtl/czh_if.sv @@
// Interfaces: request and result channels of the Zobrist hash block.
`timescale 1ns / 1ps

interface czh_in_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [9:0]            table_index;
  logic [63:0]           table_value;
  logic [5:0]            square;
  logic [3:0]            piece_code;
  logic [3:0]            castle_rights;
  logic                  ep_present;
  logic [2:0]            ep_file;
  logic                  white_to_move;

  modport source (
    output valid, kind, table_index, table_value, square, piece_code,
           castle_rights, ep_present, ep_file, white_to_move,
    input  ready
  );
  modport sink (
    input  valid, kind, table_index, table_value, square, piece_code,
           castle_rights, ep_present, ep_file, white_to_move,
    output ready
  );
endinterface

interface czh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] position_hash;

  modport source (output valid, position_hash, input ready);
  modport sink (input valid, position_hash, output ready);
endinterface

@@ hw/rtl/czh_table.sv @@
// Random table storage: piece-square words in a memory, special words in registers.
`timescale 1ns / 1ps

module czh_table
  import czh_pkg::*;
(
  input  logic         clk_i,
  input  czh_tbl_req_t req_i,
  output czh_tbl_rsp_t rsp_o
);

  logic [HashW-1:0] mem [PieceWords];
  logic [HashW-1:0] rd_data_q;
  logic [CastleWords-1:0][HashW-1:0] castle_q;
  logic [EpWords-1:0][HashW-1:0]     ep_q;
  logic [HashW-1:0]                  turn_q;

  logic [IndexW-1:0] castle_off;
  logic [IndexW-1:0] ep_off;
  logic              wr_piece;
  logic              wr_castle;
  logic              wr_ep;
  logic              wr_turn;

  assign castle_off = req_i.wr_index - IndexW'(CastleBase);
  assign ep_off     = req_i.wr_index - IndexW'(EpBase);

  assign wr_piece  = req_i.wr_en && (req_i.wr_index < IndexW'(PieceWords));
  assign wr_castle = req_i.wr_en && (req_i.wr_index >= IndexW'(CastleBase))
                     && (req_i.wr_index < IndexW'(EpBase));
  assign wr_ep     = req_i.wr_en && (req_i.wr_index >= IndexW'(EpBase))
                     && (req_i.wr_index < IndexW'(TurnWord));
  assign wr_turn   = req_i.wr_en && (req_i.wr_index == IndexW'(TurnWord));

  always_ff @(posedge clk_i) begin
    if (wr_piece) begin
      mem[req_i.wr_index[PieceAddrW-1:0]] <= req_i.wr_value;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_castle) begin
      castle_q[castle_off[1:0]] <= req_i.wr_value;
    end
    if (wr_ep) begin
      ep_q[ep_off[FileW-1:0]] <= req_i.wr_value;
    end
    if (wr_turn) begin
      turn_q <= req_i.wr_value;
    end
  end

  assign rsp_o.piece_word  = rd_data_q;
  assign rsp_o.castle_word = castle_q;
  assign rsp_o.ep_word     = ep_q;
  assign rsp_o.turn_word   = turn_q;

endmodule

@@ hw/rtl/chess_position_zobrist_hash.sv @@
// Top level: Zobrist hash of a chess position built from a stream of requests.
//
// Requests arrive on req_i (valid/ready). A load request writes one word of the
// 781-word random table; a square request XORs the word for its piece and square
// into the running hash and notes pawns; a finish request adds castling,
// en-passant and side-to-move words and sends the hash on rsp_o (valid/ready).
// Each table word must be loaded before a request uses it.
//
// Throughput: one request per cycle unless a stalled finish holds the work stage.
// A request is taken at the edge it is accepted, the table memory read happens
// on that edge, and the request sits in one work stage the next cycle.
// A finish request's hash goes via the result register to rsp_o. That register
// holds a hash while rsp_o is stalled; load and square requests keep flowing,
// and a second finish request waits in the work stage, holding req_i.ready low.
//
// Reset clears the running hash, pawn maps and all valid flags. The random
// table is not cleared and needs no clearing pass: it must be reloaded.
`timescale 1ns / 1ps

module chess_position_zobrist_hash
  import czh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  czh_in_if.sink     req_i,
  czh_out_if.source  rsp_o
);

  czh_tbl_req_t tbl_req;
  czh_tbl_rsp_t tbl_rsp;

  logic                 acc;
  logic                 s1_go;
  logic                 s1_valid_q;
  czh_kind_e            s1_kind_q;
  logic [SquareW-1:0]   s1_sq_q;
  logic [CodeW-1:0]     s1_code_q;
  logic [3:0]           s1_castle_q;
  logic                 s1_ep_present_q;
  logic [FileW-1:0]     s1_ep_file_q;
  logic                 s1_wtm_q;

  logic [HashW-1:0]     run_hash_q, run_hash_d;
  logic [Squares-1:0]   wpawn_q, wpawn_d;
  logic [Squares-1:0]   bpawn_q, bpawn_d;
  logic                 out_valid_q, out_valid_d;
  logic [HashW-1:0]     out_hash_q, out_hash_d;

  logic                 s1_square;
  logic                 s1_finish;
  logic [Squares-1:0]   side_map;
  logic [RankW-1:0]     ep_rank;
  logic [SquareW-1:0]   left_idx;
  logic [SquareW-1:0]   right_idx;
  logic                 ep_capture;
  logic [HashW-1:0]     fin_hash;

  assign s1_square = (s1_kind_q == KIND_SQUARE) && (s1_code_q <= CodeW'(MaxCode));
  assign s1_finish = (s1_kind_q == KIND_FINISH);

  assign s1_go      = s1_valid_q && !(s1_finish && out_valid_q && !rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_go;
  assign acc         = req_i.valid && req_i.ready;

  assign tbl_req.wr_en    = acc && (req_i.kind == KIND_LOAD);
  assign tbl_req.wr_index = req_i.table_index;
  assign tbl_req.wr_value = req_i.table_value;
  assign tbl_req.rd_en    = acc && (req_i.kind == KIND_SQUARE)
                            && (req_i.piece_code <= CodeW'(MaxCode));
  assign tbl_req.rd_addr  = {req_i.piece_code, req_i.square};

  czh_table u_table (
    .clk_i (clk_i),
    .req_i (tbl_req),
    .rsp_o (tbl_rsp)
  );

  // en-passant capture check: a pawn of the mover beside the pushed pawn
  always_comb begin
    side_map   = s1_wtm_q ? wpawn_q : bpawn_q;
    ep_rank    = s1_wtm_q ? RankWhiteEp : RankBlackEp;
    left_idx   = {ep_rank, s1_ep_file_q - 3'd1};
    right_idx  = {ep_rank, s1_ep_file_q + 3'd1};
    ep_capture = s1_ep_present_q &&
                 (((s1_ep_file_q != FileFirst) && side_map[left_idx]) ||
                  ((s1_ep_file_q != FileLast) && side_map[right_idx]));
  end

  always_comb begin
    fin_hash = run_hash_q;
    for (int b = 0; b < CastleWords; b++) begin
      if (s1_castle_q[b]) begin
        fin_hash = fin_hash ^ tbl_rsp.castle_word[b];
      end
    end
    if (ep_capture) begin
      fin_hash = fin_hash ^ tbl_rsp.ep_word[s1_ep_file_q];
    end
    if (s1_wtm_q) begin
      fin_hash = fin_hash ^ tbl_rsp.turn_word;
    end
  end

  always_comb begin
    run_hash_d  = run_hash_q;
    wpawn_d     = wpawn_q;
    bpawn_d     = bpawn_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_hash_d  = out_hash_q;
    if (s1_go) begin
      if (s1_square) begin
        run_hash_d = run_hash_q ^ tbl_rsp.piece_word;
        if (s1_code_q == CodeWhitePawn) begin
          wpawn_d = wpawn_q | (Squares'(1) << s1_sq_q);
        end else if (s1_code_q == CodeBlackPawn) begin
          bpawn_d = bpawn_q | (Squares'(1) << s1_sq_q);
        end
      end else if (s1_finish) begin
        out_valid_d = 1'b1;
        out_hash_d  = fin_hash;
        run_hash_d  = '0;
        wpawn_d     = '0;
        bpawn_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      run_hash_q  <= '0;
      wpawn_q     <= '0;
      bpawn_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      run_hash_q  <= run_hash_d;
      wpawn_q     <= wpawn_d;
      bpawn_q     <= bpawn_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_kind_q       <= czh_kind_e'(req_i.kind);
      s1_sq_q         <= req_i.square;
      s1_code_q       <= req_i.piece_code;
      s1_castle_q     <= req_i.castle_rights;
      s1_ep_present_q <= req_i.ep_present;
      s1_ep_file_q    <= req_i.ep_file;
      s1_wtm_q        <= req_i.white_to_move;
    end
    out_hash_q <= out_hash_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.position_hash = out_hash_q;

endmodule
